[rtl/core/sync_length_frame_deframer_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the sync length frame deframer
// Concurrent assertion wrappers that are compiled away for synthesis.
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
// Property checked at every clock edge outside reset.
`define SLDF_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sldf assertion failed");
// Property checked at every clock edge, reset included.
`define SLDF_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("sldf assertion failed");
`else
`define SLDF_ASSERT(name, clk, rst_n, prop)
`define SLDF_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[rtl/core/sldf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sync length frame deframer package
// Shared types and constants of the deframer front end, queue and back end.
// ---------------------------------------------------------------------------
package sldf_pkg;

    localparam int ByteW  = 8;
    localparam int LenW   = 16;
    localparam int CfgIdxW = 1;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 1'd1;

    localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'hDA;
    localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'hDB;

    // Queue between front and back end.
    localparam int QDepth = 2;
    localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        EV_ABSORB  = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_HDR_ERR = 2'd2,
        EV_EMPTY   = 2'd3
    } t_event_kind_e;

    // One classified result on its way to the output.
    typedef struct packed {
        t_event_kind_e    kind;
        logic [ByteW-1:0] data;
        logic             last;
    } t_item_s;

endpackage

[rtl/core/sync_length_frame_deframer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sync length frame deframer
// Splits a byte stream into frames of sync bytes, length and payload.
// ---------------------------------------------------------------------------
// Usage: the slave stream takes one received byte per item. Every byte gives
// exactly one item on the master stream: tuser carries the event kind (byte
// absorbed, payload byte, header error, empty frame), tdata the payload byte
// (zero for the other kinds) and tlast marks the final payload byte of a
// frame or an empty frame. A frame is two sync bytes, a 16-bit big-endian
// length and that many payload bytes.
// Throughput is one item per cycle in both directions while the receiver
// does not stall. An accepted item goes into the two-entry queue, then into
// the master side's output register once that is empty or being drained.
// The sync values are written through the configuration port. The user must
// write them only while the block is idle; the block does not enforce it.
// Reset restores them to 0xDA and 0xDB, empties the queue and output
// register and restarts the header search.
// When the receiver stalls, the output register holds its item and the
// queue absorbs up to two more bytes before s_tready falls.
// ---------------------------------------------------------------------------
module sync_length_frame_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port: index 0 is sync_first, index 1 sync_second.
    input  logic                         i_cfg_we,
    input  logic [sldf_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [sldf_pkg::ByteW-1:0]   i_cfg_data,
    // Slave stream of received bytes.
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [sldf_pkg::ByteW-1:0]   i_s_tdata,   // [7:0] in_byte
    // Master stream of events.
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [sldf_pkg::ByteW-1:0]   o_m_tdata,   // [7:0] out_byte
    output logic [1:0]                   o_m_tuser,   // [1:0] event_kind
    output logic                         o_m_tlast    // frame_last
);
    import sldf_pkg::*;

    logic    w_q_ready;
    logic    w_push;
    t_item_s w_push_item;
    logic    w_pop;
    logic    w_nonempty;
    t_item_s w_head_item;

    // Front end: header tracking and classification of each byte.
    sldf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_s_tvalid),
        .i_byte    (i_s_tdata),
        .i_q_ready (w_q_ready),
        .o_ready   (o_s_tready),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    // Queue decoupling the classification from the output handshake.
    sldf_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_item    (w_push_item),
        .o_ready   (w_q_ready),
        .i_pop     (w_pop),
        .o_nonempty(w_nonempty),
        .o_item    (w_head_item)
    );

    // Back end: registered master stream.
    sldf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_nonempty(w_nonempty),
        .i_item    (w_head_item),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata),
        .o_user    (o_m_tuser),
        .o_last    (o_m_tlast)
    );

endmodule

[rtl/core/sldf_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer front end
// Tracks the frame header and payload count and classifies every byte.
// ---------------------------------------------------------------------------
`include "sync_length_frame_deframer_defines.svh"

module sldf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sldf_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [sldf_pkg::ByteW-1:0]   i_cfg_data,
    input  logic                         i_valid,
    input  logic [sldf_pkg::ByteW-1:0]   i_byte,
    input  logic                         i_q_ready,
    output logic                         o_ready,
    output logic                         o_push,
    output sldf_pkg::t_item_s            o_item
);
    import sldf_pkg::*;

    typedef enum logic [2:0] {
        S_SYNC1 = 3'd0,
        S_SYNC2 = 3'd1,
        S_LENH  = 3'd2,
        S_LENL  = 3'd3,
        S_DATA  = 3'd4
    } t_phase_e;

    t_phase_e         r_phase, n_phase;
    logic [ByteW-1:0] r_len_high, n_len_high;
    logic [LenW-1:0]  r_remaining, n_remaining;
    logic [ByteW-1:0] r_sync_first, r_sync_second;
    logic [LenW-1:0]  w_len;
    logic [LenW-1:0]  w_rem_dec;
    logic             w_accept;
    t_item_s          w_item;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;
    assign o_push   = w_accept;
    assign o_item   = w_item;

    assign w_len     = {r_len_high, i_byte};
    assign w_rem_dec = r_remaining - LenW'(1);

    always_comb begin
        n_phase     = r_phase;
        n_len_high  = r_len_high;
        n_remaining = r_remaining;
        w_item.kind = EV_ABSORB;
        w_item.data = '0;
        w_item.last = 1'b0;
        unique case (r_phase)
            S_SYNC2: begin
                if (i_byte == r_sync_second) begin
                    n_phase = S_LENH;
                end else begin
                    // The partial frame is dropped; this byte is not retried.
                    n_phase     = S_SYNC1;
                    w_item.kind = EV_HDR_ERR;
                end
            end
            S_LENH: begin
                n_len_high = i_byte;
                n_phase    = S_LENL;
            end
            S_LENL: begin
                n_remaining = w_len;
                if (w_len == '0) begin
                    n_phase     = S_SYNC1;
                    w_item.kind = EV_EMPTY;
                    w_item.last = 1'b1;
                end else begin
                    n_phase = S_DATA;
                end
            end
            S_DATA: begin
                n_remaining = w_rem_dec;
                w_item.kind = EV_PAYLOAD;
                w_item.data = i_byte;
                if (w_rem_dec == '0) begin
                    n_phase     = S_SYNC1;
                    w_item.last = 1'b1;
                end
            end
            default: begin
                if (i_byte == r_sync_first) begin
                    n_phase = S_SYNC2;
                end else begin
                    n_phase     = S_SYNC1;
                    w_item.kind = EV_HDR_ERR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= S_SYNC1;
            r_len_high    <= '0;
            r_remaining   <= '0;
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_len_high  <= n_len_high;
                r_remaining <= n_remaining;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // While payload is being received at least one byte is still owed.
    `SLDF_ASSERT(a_data_count_nonzero, i_clk, i_rst_n, (r_phase == S_DATA) |-> (r_remaining != '0))
    // Only a payload byte or an empty frame closes a frame.
    `SLDF_ASSERT(a_last_kind, i_clk, i_rst_n, (o_push && w_item.last) |-> (w_item.kind == EV_PAYLOAD || w_item.kind == EV_EMPTY))
    // A closed frame always returns the header search to its start.
    `SLDF_ASSERT(a_last_rearms, i_clk, i_rst_n, (o_push && w_item.last) |=> (r_phase == S_SYNC1))

endmodule

[rtl/core/sldf_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer item queue
// Short first-in first-out buffer between the front and back end.
// ---------------------------------------------------------------------------
`include "sync_length_frame_deframer_defines.svh"

module sldf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sldf_pkg::t_item_s i_item,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_nonempty,
    output sldf_pkg::t_item_s o_item
);
    import sldf_pkg::*;

    t_item_s           r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCntW-1:0]  r_count, n_count;

    assign o_ready    = (r_count != QCntW'(QDepth));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPtrW'(QDepth - 1)) ? '0 : r_wr_ptr + QPtrW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPtrW'(QDepth - 1)) ? '0 : r_rd_ptr + QPtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCntW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `SLDF_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCntW'(QDepth))
    `SLDF_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> o_ready)
    `SLDF_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_nonempty)

endmodule

[rtl/core/sldf_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer back end
// Output register that presents queued items on the master stream.
// ---------------------------------------------------------------------------
module sldf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_nonempty,
    input  sldf_pkg::t_item_s          i_item,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sldf_pkg::ByteW-1:0] o_data,
    output logic [1:0]                 o_user,
    output logic                       o_last
);
    import sldf_pkg::*;

    logic    r_valid;
    t_item_s r_item;

    // Load a new item whenever the register is empty or being drained.
    assign o_pop   = i_nonempty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_item.data;
    assign o_user  = r_item.kind;
    assign o_last  = r_item.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

endmodule

[dv/sync_length_frame_deframer_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sync length frame deframer checker
// Watches the configuration port and both streams, predicts one event per
// accepted byte and compares every delivered item with the oldest prediction.
// ---------------------------------------------------------------------------
module sync_length_frame_deframer_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sldf_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [sldf_pkg::ByteW-1:0]   i_cfg_data,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [sldf_pkg::ByteW-1:0]   i_s_tdata,   // [7:0] in_byte
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [sldf_pkg::ByteW-1:0]   i_m_tdata,   // [7:0] out_byte
    input  logic [1:0]                   i_m_tuser,   // [1:0] event_kind
    input  logic                         i_m_tlast,
    output int                           o_fail_count,
    output int                           o_pending
);
    import sldf_pkg::*;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        LEN_HIGH,
        LEN_LOW,
        PAYLOAD
    } t_hdr_phase_e;

    logic [ByteW-1:0] want_first;
    logic [ByteW-1:0] want_second;
    t_hdr_phase_e     hdr_phase;
    logic [ByteW-1:0] len_high;
    logic [LenW-1:0]  bytes_left;

    t_item_s          expected_events[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Advances the frame parser by one received byte and returns its event.
    function automatic t_item_s next_event(input logic [ByteW-1:0] rx_byte);
        t_item_s         ev;
        logic [LenW-1:0] frame_len;
        ev.kind   = EV_ABSORB;
        ev.data   = '0;
        ev.last   = 1'b0;
        frame_len = {len_high, rx_byte};
        case (hdr_phase)
            HUNT_SECOND: begin
                if (rx_byte == want_second) begin
                    hdr_phase = LEN_HIGH;
                end else begin
                    // The failing byte is dropped, not retried as a first sync.
                    hdr_phase = HUNT_FIRST;
                    ev.kind   = EV_HDR_ERR;
                end
            end
            LEN_HIGH: begin
                len_high  = rx_byte;
                hdr_phase = LEN_LOW;
            end
            LEN_LOW: begin
                if (frame_len == '0) begin
                    hdr_phase  = HUNT_FIRST;
                    bytes_left = '0;
                    ev.kind    = EV_EMPTY;
                    ev.last    = 1'b1;
                end else begin
                    bytes_left = frame_len;
                    hdr_phase  = PAYLOAD;
                end
            end
            PAYLOAD: begin
                bytes_left = bytes_left - LenW'(1);
                ev.kind    = EV_PAYLOAD;
                ev.data    = rx_byte;
                if (bytes_left == '0) begin
                    ev.last   = 1'b1;
                    hdr_phase = HUNT_FIRST;
                end
            end
            default: begin
                if (rx_byte == want_first) begin
                    hdr_phase = HUNT_SECOND;
                end else begin
                    hdr_phase = HUNT_FIRST;
                    ev.kind   = EV_HDR_ERR;
                end
            end
        endcase
        return ev;
    endfunction

    always @(posedge i_clk) begin
        t_item_s exp_ev;
        if (!i_rst_n) begin
            want_first  = SYNC_FIRST_RST;
            want_second = SYNC_SECOND_RST;
            hdr_phase   = HUNT_FIRST;
            len_high    = '0;
            bytes_left  = '0;
            expected_events.delete();
        end else begin
            // A byte taken at this edge still sees the old sync values.
            if (i_s_tvalid && i_s_tready) begin
                expected_events = {expected_events, next_event(i_s_tdata)};
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_FIRST:  want_first  = i_cfg_data;
                    CFG_SYNC_SECOND: want_second = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_events.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("mismatch: unexpected item kind %0d data %02h last %0b",
                                 i_m_tuser, i_m_tdata, i_m_tlast);
                    end
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (i_m_tuser !== exp_ev.kind || i_m_tdata !== exp_ev.data ||
                        i_m_tlast !== exp_ev.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("mismatch: expected kind %0d data %02h last %0b, %s",
                                     exp_ev.kind, exp_ev.data, exp_ev.last, "got");
                            $display("          kind %0d data %02h last %0b",
                                     i_m_tuser, i_m_tdata, i_m_tlast);
                        end
                    end
                end
            end
        end
        o_pending = expected_events.size();
    end

endmodule

[dv/sync_length_frame_deframer_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sync length frame deframer testbench
// Feeds headers, frames of many lengths, noise and broken headers under
// several sync settings and flow control patterns; a checker beside the
// block predicts and compares every event item.
// ---------------------------------------------------------------------------
module sync_length_frame_deframer_tb;
    import sldf_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CfgIdxW-1:0]   i_cfg_idx;
    logic [ByteW-1:0]     i_cfg_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [ByteW-1:0]     i_s_tdata;   // [7:0] in_byte
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [ByteW-1:0]     o_m_tdata;   // [7:0] out_byte
    logic [1:0]           o_m_tuser;   // [1:0] event_kind
    logic                 o_m_tlast;

    int                   fail_count;
    int                   pending_events;

    // Flow control knobs, in percent of cycles. The receiver hold-off is a
    // cycle count that the receiver process runs down on its own.
    int unsigned          tx_idle_pct;
    int unsigned          rx_stall_pct;
    int unsigned          rx_hold_left;

    // Sync values currently programmed, so that frames can be built.
    logic [ByteW-1:0]     sync_a;
    logic [ByteW-1:0]     sync_b;
    int unsigned          sent_items;

    sync_length_frame_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    sync_length_frame_deframer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_events)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run must finish well within this; the slowest legal run takes a
    // small fraction of it.
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: a pending hold-off forces tready low for its whole length,
    // otherwise tready drops at random by the current stall rate.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_m_tready   = 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else begin
                i_m_tready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offers one byte, with random idle cycles in front, and returns at the
    // falling edge after the handshake. tvalid stays high on return so that
    // back-to-back items need no gap.
    task automatic send_byte(input logic [ByteW-1:0] rx_byte);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = rx_byte;
        do @(posedge i_clk); while (!o_s_tready);
        sent_items++;
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every predicted event has been taken.
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (pending_events != 0) @(negedge i_clk);
    endtask

    // Registers are only written once the block has nothing in flight.
    task automatic write_sync(input logic [ByteW-1:0] first_val,
                              input logic [ByteW-1:0] second_val);
        wait_drained();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = CFG_SYNC_FIRST;
        i_cfg_data = first_val;
        @(negedge i_clk);
        i_cfg_idx  = CFG_SYNC_SECOND;
        i_cfg_data = second_val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sync_a     = first_val;
        sync_b     = second_val;
    endtask

    // A well-formed frame with a random payload.
    task automatic send_frame(input logic [LenW-1:0] frame_len);
        send_byte(sync_a);
        send_byte(sync_b);
        send_byte(frame_len[15:8]);
        send_byte(frame_len[7:0]);
        for (int unsigned k = 0; k < frame_len; k++) begin
            send_byte(ByteW'($urandom));
        end
    endtask

    // Mostly complete frames with short lengths, some empty and a few a few
    // hundred bytes long; the rest is noise and headers that break off.
    // Noise never matches the first sync byte, so it cannot open a frame of
    // random and possibly huge length.
    task automatic random_traffic(input int unsigned n_items);
        int unsigned      start_cnt;
        int unsigned      roll;
        int unsigned      len_roll;
        logic [LenW-1:0]  frame_len;
        logic [ByteW-1:0] noise;
        start_cnt = sent_items;
        while (sent_items - start_cnt < n_items) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
                len_roll = $urandom_range(99);
                if (len_roll < 10) begin
                    frame_len = '0;
                end else if (len_roll < 95) begin
                    frame_len = LenW'($urandom_range(1, 16));
                end else begin
                    frame_len = LenW'($urandom_range(200, 300));
                end
                send_frame(frame_len);
            end else if (roll < 88) begin
                repeat ($urandom_range(1, 3)) begin
                    noise = ByteW'($urandom);
                    if (noise == sync_a) begin
                        noise = noise ^ 8'h01;
                    end
                    send_byte(noise);
                end
            end else begin
                // First sync followed by a wrong second byte.
                send_byte(sync_a);
                send_byte(sync_b ^ ByteW'($urandom_range(1, 255)));
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_SYNC_FIRST;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = 0;
        sync_a       = SYNC_FIRST_RST;
        sync_b       = SYNC_SECOND_RST;
        sent_items   = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset sync values, with no idling.
        // Bytes that are not a first sync byte, at both extremes.
        send_byte(8'h00);
        send_byte(8'hFF);
        // A good first sync, then the first sync value again in the second
        // position: that byte is an error and is not taken as a new start,
        // so the following second sync value is an error too.
        send_byte(sync_a);
        send_byte(sync_a);
        send_byte(sync_b);
        // Zero length frame.
        send_byte(sync_a);
        send_byte(sync_b);
        send_byte(8'h00);
        send_byte(8'h00);
        // One byte frame, then a two byte frame with extreme payloads.
        send_byte(sync_a);
        send_byte(sync_b);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hA5);
        send_byte(sync_a);
        send_byte(sync_b);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        // A frame whose length uses the high length byte, so the payload
        // count runs down across the byte boundary.
        send_frame(16'h0101);

        // Random part: one phase per flow control pattern, each under its
        // own sync setting, the extremes among them.
        random_traffic(100);

        write_sync(8'h00, 8'hFF);
        tx_idle_pct  = 78;
        rx_stall_pct = 0;
        random_traffic(50);
        // Pause mid-phase until everything has come out.
        wait_drained();
        random_traffic(50);

        write_sync(8'hFF, 8'h00);
        tx_idle_pct  = 0;
        rx_stall_pct = 78;
        random_traffic(100);

        write_sync(8'h5A, 8'h5A);
        tx_idle_pct  = 7;
        rx_stall_pct = 7;
        random_traffic(100);

        // Long receiver hold-off while the sender keeps offering, so the
        // queue fills and the input stalls.
        write_sync(ByteW'($urandom), ByteW'($urandom));
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = 300;
        random_traffic(100);

        write_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
        random_traffic(20);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending_events == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
